/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk; all but CRSS_ASSERT_RST are qualified by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define CRSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crss assertion failed");

// Next-cycle implication, off while in reset.
`define CRSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crss assertion failed");

// Next-cycle implication that also holds across reset.
`define CRSS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crss assertion failed");

`endif

/* sv/crss_pkg.sv */
// ----------------------------------------------------------------------------
// crss_pkg
// Shared constants and types of the Catmull-Rom spline sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package crss_pkg;

  // Blend weights are signed Q2.14
  localparam int WGT_W     = 16;
  localparam int FRAC_BITS = 14;
  localparam logic signed [WGT_W-1:0] WGT_ONE = 16'sd16384;

  // Rounding offsets for ties away from zero before the >>> FRAC_BITS
  localparam int RND_POS = 8192;
  localparam int RND_NEG = 8191;

  // Side-band flags that travel with each sample down the pipe
  typedef struct packed {
    logic end_of_run;
    logic curve_end;
    logic too_few_points;
  } crss_tag_t;

endpackage

`default_nettype wire

/* sv/crss_if.sv */
// ----------------------------------------------------------------------------
// crss_in_if / crss_out_if
// Valid/ready channels for control points and curve samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface crss_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface crss_out_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] sample_x;
  logic signed [COORD_WIDTH-1:0] sample_y;
  logic                          end_of_run;
  logic                          curve_end;
  logic                          too_few_points;

  modport source (output valid, sample_x, sample_y, end_of_run, curve_end,
                  too_few_points, input ready);
  modport sink   (input valid, sample_x, sample_y, end_of_run, curve_end,
                  too_few_points, output ready);
endinterface

`default_nettype wire

/* sv/catmull_rom_spline_sampler_unit.sv */
// Path: a point's first result passes the job register, s1, s2, s3 and the output register.
// Throughput: one result per cycle while the output is not stalled; an item holds
//   the issue sequencer until all its results have issued (SAMPLES_PER_SEGMENT per
//   segment, plus one for a curve's final point).
// Reset (rst_n, synchronous, active low) empties the pipe and the history.
// ----------------------------------------------------------------------------
// catmull_rom_spline_sampler_unit
// Streams 2D control points and emits uniform Catmull-Rom curve samples.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_spline_sampler_unit #(
  parameter int SAMPLES_PER_SEGMENT = 10,
  parameter int COORD_WIDTH         = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  crss_in_if.sink    in_ch,
  crss_out_if.source out_ch
);

  // --------------------------------------------------------------------------
  // Widths
  //   PW  : control points incl. mirrored ones (2*p - q needs two extra bits)
  //   PRW : one weight * point product
  //   SW  : sum of the four products
  // --------------------------------------------------------------------------
  localparam int S   = SAMPLES_PER_SEGMENT;
  localparam int W   = COORD_WIDTH;
  localparam int JW  = $clog2(S);
  localparam int PW  = W + 2;
  localparam int PRW = PW + crss_pkg::WGT_W;
  localparam int SW  = PRW + 2;
  localparam longint S3 = longint'(S) * S * S;

  // --------------------------------------------------------------------------
  // Weight table, one row per sample index j, built at elaboration.
  // The spline's 1/2 is folded in (8192 = 16384/2). Rounded to nearest,
  // ties away from zero.
  // --------------------------------------------------------------------------
  logic signed [crss_pkg::WGT_W-1:0] wgt_c [S][4];

  for (genvar g = 0; g < S; g++) begin : g_wgt
    localparam longint T  = longint'(g);
    localparam longint N1 = 8192 * (-T*T*T + 2*T*T*S - T*S*S);
    localparam longint N2 = 8192 * (3*T*T*T - 5*T*T*S + 2*S3);
    localparam longint N3 = 8192 * (-3*T*T*T + 4*T*T*S + T*S*S);
    localparam longint N4 = 8192 * (T*T*T - T*T*S);
    localparam longint R1 = (N1 >= 0) ? (N1 + S3/2) / S3 : -((-N1 + S3/2) / S3);
    localparam longint R2 = (N2 >= 0) ? (N2 + S3/2) / S3 : -((-N2 + S3/2) / S3);
    localparam longint R3 = (N3 >= 0) ? (N3 + S3/2) / S3 : -((-N3 + S3/2) / S3);
    localparam longint R4 = (N4 >= 0) ? (N4 + S3/2) / S3 : -((-N4 + S3/2) / S3);
    assign wgt_c[g][0] = crss_pkg::WGT_W'(R1);
    assign wgt_c[g][1] = crss_pkg::WGT_W'(R2);
    assign wgt_c[g][2] = crss_pkg::WGT_W'(R3);
    assign wgt_c[g][3] = crss_pkg::WGT_W'(R4);
  end

  // --------------------------------------------------------------------------
  // Pipe enable: everything moves when the output register is free or being
  // drained this cycle.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic pipe_en;

  assign pipe_en = !out_valid_r || out_ch.ready;

  // --------------------------------------------------------------------------
  // Control point history and the job register.
  // A job holds up to five window points; segment k reads win[k..k+3].
  // seg_r counts segments 0..nseg; reaching nseg selects the final op.
  // --------------------------------------------------------------------------
  logic signed [W-1:0]  hist_x_r [3];
  logic signed [W-1:0]  hist_y_r [3];
  logic [1:0]           seen_r;

  logic                 active_r;
  logic signed [PW-1:0] win_x_r [5];
  logic signed [PW-1:0] win_y_r [5];
  logic [1:0]           nseg_r;
  logic                 fin_r;
  logic                 err_r;
  logic signed [W-1:0]  fin_x_r;
  logic signed [W-1:0]  fin_y_r;
  logic [1:0]           seg_r;
  logic [JW-1:0]        j_r;

  // Issue decode for the op the sequencer presents this cycle
  logic iss_sample;
  logic iss_last;
  logic iss_fire;
  logic in_fire;

  assign iss_sample = (seg_r < nseg_r);
  assign iss_last   = iss_sample ? ((j_r == JW'(S - 1)) &&
                                    ((seg_r + 2'd1) == nseg_r) && !fin_r)
                                 : 1'b1;
  assign iss_fire   = active_r && pipe_en;

  // A new point is taken when no job is pending or the pending one issues
  // its last op now. An idle sequencer takes a point even while the output
  // is stalled.
  assign in_ch.ready = !active_r || (pipe_en && iss_last);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Job build from the history and the incoming point
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] px_e, py_e;
  logic signed [PW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [PW-1:0] win_x_nxt [5];
  logic signed [PW-1:0] win_y_nxt [5];
  logic                 job_nxt;
  logic [1:0]           nseg_nxt;
  logic                 fin_nxt;
  logic                 err_nxt;

  assign px_e = PW'(in_ch.point_x);
  assign py_e = PW'(in_ch.point_y);

  always_comb begin
    bx = PW'(hist_x_r[1]);
    by = PW'(hist_y_r[1]);
    cx = PW'(hist_x_r[2]);
    cy = PW'(hist_y_r[2]);
    // Start of curve: mirror the second point about the first
    if (seen_r == 2'd2) begin
      ax = (bx <<< 1) - cx;
      ay = (by <<< 1) - cy;
    end else begin
      ax = PW'(hist_x_r[0]);
      ay = PW'(hist_y_r[0]);
    end

    job_nxt  = 1'b0;
    nseg_nxt = 2'd0;
    fin_nxt  = 1'b0;
    err_nxt  = 1'b0;
    for (int k = 0; k < 5; k++) begin
      win_x_nxt[k] = '0;
      win_y_nxt[k] = '0;
    end

    unique case (seen_r)
      2'd0: begin
        // single-point curve: one flagged error result
        job_nxt = in_ch.last_point;
        err_nxt = 1'b1;
      end
      2'd1: begin
        // two-point curve: both ends mirrored
        job_nxt      = in_ch.last_point;
        nseg_nxt     = 2'd1;
        fin_nxt      = 1'b1;
        win_x_nxt[0] = (cx <<< 1) - px_e;
        win_y_nxt[0] = (cy <<< 1) - py_e;
        win_x_nxt[1] = cx;
        win_y_nxt[1] = cy;
        win_x_nxt[2] = px_e;
        win_y_nxt[2] = py_e;
        win_x_nxt[3] = (px_e <<< 1) - cx;
        win_y_nxt[3] = (py_e <<< 1) - cy;
      end
      default: begin
        // full window; a last point adds the closing segment
        job_nxt      = 1'b1;
        nseg_nxt     = in_ch.last_point ? 2'd2 : 2'd1;
        fin_nxt      = in_ch.last_point;
        win_x_nxt[0] = ax;
        win_y_nxt[0] = ay;
        win_x_nxt[1] = bx;
        win_y_nxt[1] = by;
        win_x_nxt[2] = cx;
        win_y_nxt[2] = cy;
        win_x_nxt[3] = px_e;
        win_y_nxt[3] = py_e;
        win_x_nxt[4] = (px_e <<< 1) - cx;
        win_y_nxt[4] = (py_e <<< 1) - cy;
      end
    endcase
  end

  // History and sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 2'd0;
      active_r <= 1'b0;
      seg_r    <= 2'd0;
      j_r      <= '0;
      for (int k = 0; k < 3; k++) begin
        hist_x_r[k] <= '0;
        hist_y_r[k] <= '0;
      end
    end else begin
      if (iss_fire) begin
        if (iss_last) begin
          active_r <= 1'b0;
        end else if (j_r == JW'(S - 1)) begin
          j_r   <= '0;
          seg_r <= seg_r + 2'd1;
        end else begin
          j_r <= j_r + JW'(1);
        end
      end
      if (in_fire) begin
        active_r <= job_nxt;
        seg_r    <= 2'd0;
        j_r      <= '0;
        if (in_ch.last_point) begin
          seen_r <= 2'd0;
          for (int k = 0; k < 3; k++) begin
            hist_x_r[k] <= '0;
            hist_y_r[k] <= '0;
          end
        end else begin
          hist_x_r[0] <= hist_x_r[1];
          hist_y_r[0] <= hist_y_r[1];
          hist_x_r[1] <= hist_x_r[2];
          hist_y_r[1] <= hist_y_r[2];
          hist_x_r[2] <= in_ch.point_x;
          hist_y_r[2] <= in_ch.point_y;
          if (seen_r != 2'd3) begin
            seen_r <= seen_r + 2'd1;
          end
        end
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_x_r <= win_x_nxt;
      win_y_r <= win_y_nxt;
      nseg_r  <= nseg_nxt;
      fin_r   <= fin_nxt;
      err_r   <= err_nxt;
      fin_x_r <= in_ch.point_x;
      fin_y_r <= in_ch.point_y;
    end
  end

  // --------------------------------------------------------------------------
  // Issue select -> stage 1. The final point rides the same datapath with
  // unit weight on one tap; the error result uses all-zero weights.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]              sel_x [4];
  logic signed [PW-1:0]              sel_y [4];
  logic signed [crss_pkg::WGT_W-1:0] sel_w [4];
  crss_pkg::crss_tag_t               sel_tag;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sel_x[k] = seg_r[0] ? win_x_r[k+1] : win_x_r[k];
      sel_y[k] = seg_r[0] ? win_y_r[k+1] : win_y_r[k];
      sel_w[k] = wgt_c[j_r][k];
    end
    if (!iss_sample) begin
      for (int k = 0; k < 4; k++) begin
        sel_x[k] = '0;
        sel_y[k] = '0;
        sel_w[k] = '0;
      end
      if (!err_r) begin
        sel_x[1] = PW'(fin_x_r);
        sel_y[1] = PW'(fin_y_r);
        sel_w[1] = crss_pkg::WGT_ONE;
      end
    end
    sel_tag.end_of_run     = iss_last;
    sel_tag.curve_end      = !iss_sample && !err_r;
    sel_tag.too_few_points = !iss_sample && err_r;
  end

  // --------------------------------------------------------------------------
  // Datapath: s1 operands -> s2 products -> s3 sums -> round/saturate -> out
  // --------------------------------------------------------------------------
  logic                              s1_v_r, s2_v_r, s3_v_r;
  logic signed [PW-1:0]              s1_x_r [4];
  logic signed [PW-1:0]              s1_y_r [4];
  logic signed [crss_pkg::WGT_W-1:0] s1_w_r [4];
  crss_pkg::crss_tag_t               s1_tag_r, s2_tag_r, s3_tag_r, out_tag_r;
  logic signed [PRW-1:0]             s2_px_r [4];
  logic signed [PRW-1:0]             s2_py_r [4];
  logic signed [SW-1:0]              s3_sx_r, s3_sy_r;
  logic signed [W-1:0]               out_x_r, out_y_r;

  // Rounding (ties away from zero) and saturation to W bits
  logic signed [SW-1:0] rnd_x, rnd_y;
  logic signed [W-1:0]  sat_x, sat_y;

  always_comb begin
    rnd_x = (s3_sx_r + (s3_sx_r[SW-1] ? SW'(crss_pkg::RND_NEG) : SW'(crss_pkg::RND_POS)))
            >>> crss_pkg::FRAC_BITS;
    rnd_y = (s3_sy_r + (s3_sy_r[SW-1] ? SW'(crss_pkg::RND_NEG) : SW'(crss_pkg::RND_POS)))
            >>> crss_pkg::FRAC_BITS;
    // In range when all bits above the W-bit sign agree with it
    if (rnd_x[SW-1:W-1] == {(SW-W+1){rnd_x[SW-1]}}) begin
      sat_x = rnd_x[W-1:0];
    end else begin
      sat_x = {rnd_x[SW-1], {(W-1){!rnd_x[SW-1]}}};
    end
    if (rnd_y[SW-1:W-1] == {(SW-W+1){rnd_y[SW-1]}}) begin
      sat_y = rnd_y[W-1:0];
    end else begin
      sat_y = {rnd_y[SW-1], {(W-1){!rnd_y[SW-1]}}};
    end
  end

  // Pipe valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r      <= active_r;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  // Pipe payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_x_r   <= sel_x;
      s1_y_r   <= sel_y;
      s1_w_r   <= sel_w;
      s1_tag_r <= sel_tag;
      for (int k = 0; k < 4; k++) begin
        s2_px_r[k] <= PRW'(s1_x_r[k]) * PRW'(s1_w_r[k]);
        s2_py_r[k] <= PRW'(s1_y_r[k]) * PRW'(s1_w_r[k]);
      end
      s2_tag_r <= s1_tag_r;
      s3_sx_r  <= SW'(s2_px_r[0]) + SW'(s2_px_r[1]) + SW'(s2_px_r[2]) + SW'(s2_px_r[3]);
      s3_sy_r  <= SW'(s2_py_r[0]) + SW'(s2_py_r[1]) + SW'(s2_py_r[2]) + SW'(s2_py_r[3]);
      s3_tag_r <= s2_tag_r;
      out_x_r   <= sat_x;
      out_y_r   <= sat_y;
      out_tag_r <= s3_tag_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample_x       = out_x_r;
  assign out_ch.sample_y       = out_y_r;
  assign out_ch.end_of_run     = out_tag_r.end_of_run;
  assign out_ch.curve_end      = out_tag_r.curve_end;
  assign out_ch.too_few_points = out_tag_r.too_few_points;

endmodule

`default_nettype wire

/* sv/crss_checker.sv */
// ----------------------------------------------------------------------------
// crss_checker
// Port-level checks on the sampler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crss_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] out_sample_x,
  input wire logic [COORD_WIDTH-1:0] out_sample_y,
  input wire logic                   out_end_of_run,
  input wire logic                   out_curve_end,
  input wire logic                   out_too_few_points
);

  // a stalled transaction holds
  `CRSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_x) && $stable(out_sample_y) && $stable(out_end_of_run) && $stable(out_curve_end) && $stable(out_too_few_points))

  // nothing comes out right after reset
  `CRSS_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

  // the error result is alone, zero and never a curve end
  `CRSS_ASSERT_IMP(a_err_shape, out_valid && out_too_few_points, out_end_of_run && !out_curve_end && (out_sample_x == '0) && (out_sample_y == '0))

  // the final point always closes its run
  `CRSS_ASSERT_IMP(a_end_closes, out_valid && out_curve_end, out_end_of_run)

endmodule

bind catmull_rom_spline_sampler_unit crss_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_crss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_sample_x      (out_ch.sample_x),
  .out_sample_y      (out_ch.sample_y),
  .out_end_of_run    (out_ch.end_of_run),
  .out_curve_end     (out_ch.curve_end),
  .out_too_few_points(out_ch.too_few_points)
);

`default_nettype wire

/* sim/catmull_rom_spline_sampler_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_spline_sampler_unit_tb
// Sends control-point curves (short directed table, then random curves) into
// the sampler. An in-bench spline predictor produces the expected sample
// stream. Every output transaction is checked field by field, in order,
// while both channels idle at random outside a steady stretch.
// ----------------------------------------------------------------------------

module catmull_rom_spline_sampler_unit_tb;

  localparam int SEG_SAMPLES  = 10;
  localparam int COORD_W      = 16;
  localparam int RANDOM_ITEMS = 291;
  localparam int STEADY_FROM  = 120;
  localparam int STEADY_TO    = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 19;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t              sample_x;
    coord_t              sample_y;
    crss_pkg::crss_tag_t tag;
  } sample_t;

  // directed stimulus; typed = 1 rows carry their expected single result
  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   last;
    logic   typed;
    coord_t want_x;
    coord_t want_y;
    logic   want_eor;
    logic   want_ce;
    logic   want_tfp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  crss_in_if  #(.COORD_WIDTH(COORD_W)) in_if ();
  crss_out_if #(.COORD_WIDTH(COORD_W)) out_if ();

  catmull_rom_spline_sampler_unit #(
    .SAMPLES_PER_SEGMENT(SEG_SAMPLES),
    .COORD_WIDTH        (COORD_W)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  stim_row_t directed_rows [N_DIRECTED] = '{
    // single-point curves straight after reset: error result
    '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1},
    // two-point curve, both ends mirrored, saturating
    '{16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    // three-point curve
    '{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    // six-point curve: full windows, extreme swings
    '{16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h0010, 16'hFFF0, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    // state must be clear after the curve end
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1},
    // smooth curve, no saturation
    '{16'h0100, 16'h0040, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h0200, 16'h0100, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h0300, 16'h0080, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'h0400, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
    '{16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1}
  };

  // spline predictor state
  longint  spline_wgt [4][SEG_SAMPLES];
  longint  hist_x [3];
  longint  hist_y [3];
  int      pts_held;
  sample_t step_samples [$];
  sample_t sample_q [$];

  int points_sent;
  int mismatch_cnt;
  bit steady;

  function automatic longint rnd_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[COORD_W-1:0];
  endfunction

  function automatic sample_t make_sample(coord_t sx, coord_t sy, logic ce, logic tfp);
    sample_t s;
    s.sample_x           = sx;
    s.sample_y           = sy;
    s.tag.end_of_run     = 1'b0;
    s.tag.curve_end      = ce;
    s.tag.too_few_points = tfp;
    return s;
  endfunction

  function automatic coord_t blend_coord(int j, longint c1, longint a, longint b, longint c2);
    return clamp_coord(rnd_div(spline_wgt[0][j] * c1 + spline_wgt[1][j] * a +
                               spline_wgt[2][j] * b + spline_wgt[3][j] * c2, 16384));
  endfunction

  function automatic void push_segment(input longint wx [4], input longint wy [4]);
    for (int j = 0; j < SEG_SAMPLES; j++)
      step_samples.push_back(make_sample(blend_coord(j, wx[0], wx[1], wx[2], wx[3]),
                                         blend_coord(j, wy[0], wy[1], wy[2], wy[3]),
                                         1'b0, 1'b0));
  endfunction

  // results of one accepted point go to step_samples
  function automatic void predict_point(coord_t px, coord_t py, logic last);
    longint  x, y, ax, ay, bx, by, cx, cy;
    longint  wx [4];
    longint  wy [4];
    sample_t tail;
    x = px;
    y = py;
    step_samples.delete();
    if (pts_held == 0 && last) begin
      step_samples.push_back(make_sample('0, '0, 1'b0, 1'b1));
    end else begin
      if (pts_held == 1 && last) begin
        ax = hist_x[2];
        ay = hist_y[2];
        wx = '{2 * ax - x, ax, x, 2 * x - ax};
        wy = '{2 * ay - y, ay, y, 2 * y - ay};
        push_segment(wx, wy);
      end else if (pts_held >= 2) begin
        bx = hist_x[1];
        by = hist_y[1];
        cx = hist_x[2];
        cy = hist_y[2];
        if (pts_held == 2) begin
          // leading end is mirrored
          ax = 2 * bx - cx;
          ay = 2 * by - cy;
        end else begin
          ax = hist_x[0];
          ay = hist_y[0];
        end
        wx = '{ax, bx, cx, x};
        wy = '{ay, by, cy, y};
        push_segment(wx, wy);
        if (last) begin
          wx = '{bx, cx, x, 2 * x - cx};
          wy = '{by, cy, y, 2 * y - cy};
          push_segment(wx, wy);
        end
      end
      if (last) step_samples.push_back(make_sample(px, py, 1'b1, 1'b0));
    end

    if (last) begin
      hist_x   = '{0, 0, 0};
      hist_y   = '{0, 0, 0};
      pts_held = 0;
    end else begin
      hist_x = '{hist_x[1], hist_x[2], x};
      hist_y = '{hist_y[1], hist_y[2], y};
      if (pts_held < 3) pts_held++;
    end

    if (step_samples.size() > 0) begin
      tail = step_samples.pop_back();
      tail.tag.end_of_run = 1'b1;
      step_samples.push_back(tail);
    end
  endfunction

  function automatic coord_t pick_coord();
    logic [COORD_W-1:0] v;
    case ($urandom_range(7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2, 3:    v = 16'($urandom);
      default: v = 16'($urandom_range(4095) - 2048);
    endcase
    return v;
  endfunction

  task automatic note_mismatch(input string what, input sample_t want, input sample_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: exp x=%0d y=%0d eor=%b ce=%b tfp=%b, got x=%0d y=%0d eor=%b ce=%b tfp=%b",
               $time, what, want.sample_x, want.sample_y, want.tag.end_of_run,
               want.tag.curve_end, want.tag.too_few_points, got.sample_x, got.sample_y,
               got.tag.end_of_run, got.tag.curve_end, got.tag.too_few_points);
  endtask

  // one point transaction; valid stays up when the next point follows at once
  task automatic send_point(input coord_t px, input coord_t py, input logic last,
                            input logic typed, input sample_t want);
    while (!steady && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.point_x    <= px;
    in_if.point_y    <= py;
    in_if.last_point <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_point(px, py, last);
    if (typed) sample_q.push_back(want);
    else foreach (step_samples[k]) sample_q.push_back(step_samples[k]);
    points_sent++;
    steady = (points_sent >= STEADY_FROM && points_sent < STEADY_TO);
  endtask

  initial begin
    longint  t, s, s3;
    int      n_pts;
    sample_t want;
    for (int j = 0; j < SEG_SAMPLES; j++) begin
      t  = j;
      s  = SEG_SAMPLES;
      s3 = s * s * s;
      spline_wgt[0][j] = rnd_div(8192 * (-t * t * t + 2 * t * t * s - t * s * s), s3);
      spline_wgt[1][j] = rnd_div(8192 * (3 * t * t * t - 5 * t * t * s + 2 * s3), s3);
      spline_wgt[2][j] = rnd_div(8192 * (-3 * t * t * t + 4 * t * t * s + t * s * s), s3);
      spline_wgt[3][j] = rnd_div(8192 * (t * t * t - t * t * s), s3);
    end
    hist_x       = '{0, 0, 0};
    hist_y       = '{0, 0, 0};
    pts_held     = 0;
    points_sent  = 0;
    mismatch_cnt = 0;
    steady       = 1'b0;

    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.point_x    <= '0;
    in_if.point_y    <= '0;
    in_if.last_point <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      want.sample_x           = directed_rows[r].want_x;
      want.sample_y           = directed_rows[r].want_y;
      want.tag.end_of_run     = directed_rows[r].want_eor;
      want.tag.curve_end      = directed_rows[r].want_ce;
      want.tag.too_few_points = directed_rows[r].want_tfp;
      send_point(directed_rows[r].px, directed_rows[r].py, directed_rows[r].last,
                 directed_rows[r].typed, want);
    end

    // random curves, mostly several points long, some single-point errors
    while (points_sent < N_DIRECTED + RANDOM_ITEMS) begin
      case ($urandom_range(19))
        0, 1:    n_pts = 1;
        2, 3, 4: n_pts = 2;
        5, 6:    n_pts = 3;
        default: n_pts = $urandom_range(12, 4);
      endcase
      for (int k = 0; k < n_pts; k++)
        send_point(pick_coord(), pick_coord(), k == n_pts - 1, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // result sink: random back-pressure, none during the steady stretch
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    sample_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.sample_x           = out_if.sample_x;
      got.sample_y           = out_if.sample_y;
      got.tag.end_of_run     = out_if.end_of_run;
      got.tag.curve_end      = out_if.curve_end;
      got.tag.too_few_points = out_if.too_few_points;
      if (sample_q.size() == 0) begin
        note_mismatch("unexpected sample", '0, got);
      end else begin
        want = sample_q.pop_front();
        if (got.sample_x !== want.sample_x || got.sample_y !== want.sample_y ||
            got.tag.end_of_run !== want.tag.end_of_run ||
            got.tag.curve_end !== want.tag.curve_end ||
            got.tag.too_few_points !== want.tag.too_few_points)
          note_mismatch("sample mismatch", want, got);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
